### hw/rtl/fpds_pkg.sv
// ----------------------------------------------------------------------------
// fpds_pkg
// shared widths, saturation values and the divider stage record
// ----------------------------------------------------------------------------
`default_nettype none

package fpds_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int SAT_SHIFT = 14;
  localparam int QUO_W     = DATA_W - 2;

  typedef logic [DATA_W-1:0] word_t;

  localparam word_t FX_MIN = 32'h8000_0000;
  localparam word_t FX_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic                 sat;
    logic                 neg;
    word_t                den;
    logic [SAT_SHIFT-1:0] num_lo;
    word_t                rem;
    logic [QUO_W-1:0]     quo;
  } div_stage_t;

endpackage

`default_nettype wire

### hw/rtl/fixed_point_divide_saturating.sv
// ----------------------------------------------------------------------------
// fixed_point_divide_saturating
// signed 16.16 divider, one quotient bit per pipeline stage, with saturation
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries a transaction of {divisor, dividend}; m_tdata returns the
//   16.16 quotient truncated toward zero and m_tuser the saturated flag.
//   a transaction is taken when tvalid and tready are both high.
// pipeline: the data passes 33 register stages: one for the operand
//   magnitudes, one for the overflow test, 30 restoring-division stages (one
//   quotient bit each) and one for sign and saturation select.
// throughput: one transaction per cycle while the receiver does not stall;
//   the 33 register stages hold up to 33 transactions in flight.
// saturation: when |dividend| >> 14 >= |divisor|, or the dividend is the most
//   negative value, the result is the most negative or most positive value
//   by operand sign and the flag is set; a zero divisor always saturates.
// reset clears all valid bits. when the receiver stalls with a result
//   waiting, the whole pipeline holds and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_divide_saturating (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [2*fpds_pkg::DATA_W-1:0] s_tdata,  // dividend, divisor
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [fpds_pkg::DATA_W-1:0]        m_tdata,  // quotient
  output logic                               m_tuser   // saturated
);
  import fpds_pkg::*;

  logic       adv;

  // operand magnitude stage
  logic       in_valid;
  word_t      in_num;
  word_t      in_den;
  logic       in_neg;

  word_t      a_raw;
  word_t      b_raw;

  // divider stages
  div_stage_t stg       [0:QUO_W];
  logic       stg_valid [0:QUO_W];

  // output register
  logic       out_valid;
  word_t      out_quo;
  logic       out_sat;

  logic [DATA_W-SAT_SHIFT-1:0] num_hi;
  word_t                       quo_ext;

  assign adv      = !out_valid || m_tready;
  assign s_tready = adv;

  assign a_raw = s_tdata[DATA_W-1:0];
  assign b_raw = s_tdata[2*DATA_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
    end
    if (adv) begin
      in_num <= a_raw[DATA_W-1] ? (~a_raw + word_t'(1)) : a_raw;
      in_den <= b_raw[DATA_W-1] ? (~b_raw + word_t'(1)) : b_raw;
      in_neg <= a_raw[DATA_W-1] ^ b_raw[DATA_W-1];
    end
  end

  assign num_hi = in_num[DATA_W-1:SAT_SHIFT];

  // overflow test and initial partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (adv) begin
      stg_valid[0] <= in_valid;
    end
    if (adv) begin
      stg[0].sat    <= in_num[DATA_W-1] || (word_t'(num_hi) >= in_den);
      stg[0].neg    <= in_neg;
      stg[0].den    <= in_den;
      stg[0].num_lo <= in_num[SAT_SHIFT-1:0];
      stg[0].rem    <= word_t'(num_hi);
      stg[0].quo    <= '0;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - k;

    logic              nbit;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              qbit;

    if (BIT >= FRAC_W) begin : g_num
      assign nbit = stg[k-1].num_lo[BIT-FRAC_W];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {stg[k-1].rem, nbit};
    assign diff  = trial - {1'b0, stg[k-1].den};
    assign qbit  = !diff[DATA_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else if (adv) begin
        stg_valid[k] <= stg_valid[k-1];
      end
      if (adv) begin
        stg[k].sat    <= stg[k-1].sat;
        stg[k].neg    <= stg[k-1].neg;
        stg[k].den    <= stg[k-1].den;
        stg[k].num_lo <= stg[k-1].num_lo;
        stg[k].rem    <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        stg[k].quo    <= {stg[k-1].quo[QUO_W-2:0], qbit};
      end
    end
  end

  assign quo_ext = word_t'(stg[QUO_W].quo);

  // sign and saturation select
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= stg_valid[QUO_W];
    end
    if (adv) begin
      out_sat <= stg[QUO_W].sat;
      if (stg[QUO_W].sat) begin
        out_quo <= stg[QUO_W].neg ? FX_MIN : FX_MAX;
      end else begin
        out_quo <= stg[QUO_W].neg ? (~quo_ext + word_t'(1)) : quo_ext;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_quo;
  assign m_tuser  = out_sat;

endmodule

`default_nettype wire

### sim/tb_fixed_point_divide_saturating.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_divide_saturating
// self-checking bench for the signed 16.16 saturating divider: a directed
// table of corner operands, then random pairs, each result checked against
// a typed entry or an in-bench predictor, with random gaps and back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fixed_point_divide_saturating;

  import fpds_pkg::*;

  localparam int NUM_RANDOM   = 1500;
  localparam int NUM_DIRECTED = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int GAP_PERCENT  = 14;

  typedef struct packed {
    word_t quotient;
    logic  saturated;
  } quot_result_t;

  typedef struct packed {
    word_t        dividend;
    word_t        divisor;
    logic         typed;
    quot_result_t result;
  } div_row_t;

  localparam div_row_t DIV_ROWS [NUM_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{FX_MAX, 1'b1}},
    '{32'h0001_0000, 32'h0000_0000, 1'b1, '{FX_MAX, 1'b1}},
    '{32'hffff_0000, 32'h0000_0000, 1'b1, '{FX_MIN, 1'b1}},
    '{FX_MIN,        32'h0000_0000, 1'b1, '{FX_MIN, 1'b1}},
    '{FX_MIN,        32'h0001_0000, 1'b1, '{FX_MIN, 1'b1}},
    '{FX_MIN,        FX_MIN,        1'b1, '{FX_MAX, 1'b1}},
    '{FX_MAX,        32'h0000_0001, 1'b1, '{FX_MAX, 1'b1}},
    '{FX_MAX,        32'h0001_ffff, 1'b1, '{FX_MAX, 1'b1}},
    '{32'h0000_4000, 32'hffff_ffff, 1'b1, '{FX_MIN, 1'b1}},
    '{32'h0000_3fff, 32'h0000_0001, 1'b0, '0},
    '{FX_MAX,        32'h0002_0000, 1'b0, '0},
    '{FX_MAX,        FX_MIN,        1'b0, '0},
    '{32'h8000_0001, FX_MAX,        1'b0, '0},
    '{32'h8000_0001, 32'h0002_0000, 1'b0, '0},
    '{32'hffff_ffff, FX_MIN,        1'b0, '0},
    '{32'h0001_0000, 32'h0001_0000, 1'b1, '{32'h0001_0000, 1'b0}},
    '{32'h0001_0000, 32'hffff_0000, 1'b1, '{32'hffff_0000, 1'b0}},
    '{32'h0000_0000, 32'h0001_0000, 1'b1, '{32'h0000_0000, 1'b0}},
    '{32'h0000_0000, 32'hffff_0000, 1'b1, '{32'h0000_0000, 1'b0}},
    '{32'h0000_0001, FX_MAX,        1'b0, '0},
    '{32'hffff_ffff, FX_MAX,        1'b0, '0},
    '{32'h0003_0000, 32'h0002_0000, 1'b0, '0},
    '{32'hfffd_0000, 32'h0002_0000, 1'b0, '0},
    '{32'h0000_8000, FX_MIN,        1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [2*DATA_W-1:0]   s_tdata = '0;  // dividend, divisor
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;       // quotient
  logic                  m_tuser;       // saturated

  logic                  row_typed = 1'b0;
  quot_result_t          row_result = '0;
  logic                  no_gaps = 1'b0;
  quot_result_t          pending_quotients [$];
  int                    fail_count = 0;
  int                    cycle_count = 0;

  fixed_point_divide_saturating u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic word_t abs_word(word_t v);
    return v[DATA_W-1] ? -v : v;
  endfunction

  function automatic quot_result_t predict_quotient(word_t dividend, word_t divisor);
    logic [63:0]  num_mag;
    logic [63:0]  den_mag;
    logic [63:0]  quo_wide;
    word_t        quo;
    logic         neg;
    quot_result_t r;
    neg     = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    num_mag = {32'b0, abs_word(dividend)};
    den_mag = {32'b0, abs_word(divisor)};
    if (dividend == FX_MIN || (num_mag >> SAT_SHIFT) >= den_mag) begin
      r.quotient  = neg ? FX_MIN : FX_MAX;
      r.saturated = 1'b1;
    end else begin
      quo_wide    = (num_mag << FRAC_W) / den_mag;
      quo         = quo_wide[DATA_W-1:0];
      r.quotient  = neg ? -quo : quo;
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  // operand mix: full range, scaled magnitudes, the saturation boundary, extremes
  task automatic pick_operands(output word_t dividend, output word_t divisor);
    int    mode;
    word_t extremes [6];
    extremes = '{32'h0, 32'h1, 32'hffff_ffff, FX_MIN, FX_MAX, 32'h0001_0000};
    mode     = $urandom_range(0, 9);
    dividend = word_t'($urandom) >> $urandom_range(0, 31);
    divisor  = word_t'($urandom) >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) dividend = -dividend;
    if ($urandom_range(0, 1)) divisor = -divisor;
    case (mode)
      0, 1, 2: begin
        dividend = $urandom;
        divisor  = $urandom;
      end
      7: begin
        divisor = (abs_word(dividend) >> SAT_SHIFT) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) divisor = -divisor;
      end
      8: divisor = extremes[$urandom_range(0, 5)];
      9: dividend = extremes[$urandom_range(0, 5)];
      default: ;
    endcase
  endtask

  task automatic drive_item(word_t dividend, word_t divisor, logic typed,
                            quot_result_t result, logic steady);
    while (!steady && $urandom_range(0, 99) < GAP_PERCENT) begin
      s_tvalid <= 1'b0;
      no_gaps  <= steady;
      @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= {divisor, dividend};
    row_typed  <= typed;
    row_result <= result;
    no_gaps    <= steady;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // pop before push so a same-cycle transaction pair is ordered
  always @(posedge clk) begin : check_quotients
    quot_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_quotients.size() == 0) begin
          $error("unexpected result: quotient %h saturated %b", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = pending_quotients.pop_front();
          if (m_tdata !== want.quotient) begin
            $error("quotient: expected %h, actual %h", want.quotient, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.saturated) begin
            $error("saturated: expected %b, actual %b", want.saturated, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_quotients.push_back(row_typed ? row_result :
          predict_quotient(s_tdata[DATA_W-1:0], s_tdata[2*DATA_W-1:DATA_W]));
      end
    end
  end

  initial begin
    word_t dividend;
    word_t divisor;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      drive_item(DIV_ROWS[i].dividend, DIV_ROWS[i].divisor, DIV_ROWS[i].typed,
                 DIV_ROWS[i].result, 1'b0);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      pick_operands(dividend, divisor);
      drive_item(dividend, divisor, 1'b0, '0, i >= 700 && i < 1000);
    end
    s_tvalid <= 1'b0;
    no_gaps  <= 1'b0;
    @(posedge clk);
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_quotients.size() != 0) begin
      $error("%0d expected results never arrived", pending_quotients.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fpds_pkg.sv
hw/rtl/fixed_point_divide_saturating.sv
sim/tb_fixed_point_divide_saturating.sv
